// File: design/dmxfws_pkg.sv
// Shared types and constants of the DMX512 frame word serializer.
`default_nettype none

package dmxfws_pkg;

  localparam int CNT_W       = 10;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 16;
  localparam int RUN_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int WCFG_W      = 5;

  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam int DEF_MAX_SLOTS = 512;

  localparam logic [CFG_IDX_W-1:0] CFG_MARK_BEFORE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHAN    = 2'd2;

  localparam logic [WORD_W-1:0] WORD_MARK  = 16'hFFFF;
  localparam logic [WORD_W-1:0] WORD_BREAK = 16'h0000;
  localparam logic [WORD_W-1:0] WORD_MAB   = 16'h000E;
  localparam logic [WORD_W-1:0] WORD_START = 16'h00FE;
  localparam logic [BYTE_W-1:0] LOW_CONT   = 8'hFE;
  localparam logic [BYTE_W-1:0] LOW_END    = 8'hFF;

  // One queued job: an optional preamble followed by an optional channel word.
  typedef struct packed {
    logic              pre;
    logic [RUN_W-1:0]  mbb_m1;
    logic [RUN_W-1:0]  brk_m1;
    logic              send;
    logic [BYTE_W-1:0] data;
    logic              closes;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [2:0] {
    PH_ENTRY,
    PH_MARK,
    PH_BREAK,
    PH_MAB,
    PH_START,
    PH_CHAN
  } phase_t;

endpackage

`default_nettype wire

// File: design/dmxfws_front.sv
// Front end: configuration registers, frame bookkeeping and job classification.
`default_nettype none

module dmxfws_front #(
  parameter int MAX_SLOTS = dmxfws_pkg::DEF_MAX_SLOTS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [dmxfws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dmxfws_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                  item_valid,
  output logic                                       item_ready,
  input  wire logic [dmxfws_pkg::BYTE_W-1:0]         channel_value,
  input  wire logic                                  first_of_frame,
  input  wire logic                                  last_of_frame,
  input  wire dmxfws_pkg::qstat_t                    qstat,
  output logic                                       push,
  output dmxfws_pkg::entry_t                         entry
);

  localparam logic [dmxfws_pkg::CNT_W-1:0] SlotsLim = dmxfws_pkg::CNT_W'(MAX_SLOTS);

  logic [dmxfws_pkg::WCFG_W-1:0] mark_before_words;
  logic [dmxfws_pkg::WCFG_W-1:0] break_words;
  logic [dmxfws_pkg::CNT_W-1:0]  max_channels;
  logic [dmxfws_pkg::CNT_W-1:0]  sent_channel_count;
  logic                          dropping_rest;

  logic [dmxfws_pkg::CNT_W-1:0]  limit;
  logic [dmxfws_pkg::CNT_W-1:0]  cnt0;
  logic [dmxfws_pkg::CNT_W-1:0]  cnt1;
  logic [dmxfws_pkg::RUN_W-1:0]  mbb_m1;
  logic [dmxfws_pkg::RUN_W-1:0]  brk_m1;
  logic [dmxfws_pkg::BYTE_W-1:0] rev;
  logic                          drop1;
  logic                          send;
  logic                          closes;
  logic                          take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_before_words <= dmxfws_pkg::WCFG_W'(1);
      break_words       <= dmxfws_pkg::WCFG_W'(1);
      max_channels      <= dmxfws_pkg::CNT_W'(512);
    end else if (cfg_valid) begin
      case (cfg_index)
        dmxfws_pkg::CFG_MARK_BEFORE: mark_before_words <= cfg_data[dmxfws_pkg::WCFG_W-1:0];
        dmxfws_pkg::CFG_BREAK:       break_words       <= cfg_data[dmxfws_pkg::WCFG_W-1:0];
        dmxfws_pkg::CFG_MAX_CHAN:    max_channels      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Word counts saturate to 1..16 and are kept as count minus one.
  always_comb begin
    if (mark_before_words == '0) begin
      mbb_m1 = '0;
    end else if (mark_before_words > dmxfws_pkg::WCFG_W'(16)) begin
      mbb_m1 = '1;
    end else begin
      mbb_m1 = dmxfws_pkg::RUN_W'(mark_before_words - dmxfws_pkg::WCFG_W'(1));
    end
    if (break_words == '0) begin
      brk_m1 = '0;
    end else if (break_words > dmxfws_pkg::WCFG_W'(16)) begin
      brk_m1 = '1;
    end else begin
      brk_m1 = dmxfws_pkg::RUN_W'(break_words - dmxfws_pkg::WCFG_W'(1));
    end
    if (max_channels == '0) begin
      limit = dmxfws_pkg::CNT_W'(1);
    end else if (max_channels > SlotsLim) begin
      limit = SlotsLim;
    end else begin
      limit = max_channels;
    end
  end

  always_comb begin
    for (int i = 0; i < dmxfws_pkg::BYTE_W; i++) begin
      rev[i] = channel_value[dmxfws_pkg::BYTE_W-1-i];
    end
  end

  // A frame start clears the count; a count at limit or a closed frame drops a byte.
  always_comb begin
    cnt0   = first_of_frame ? '0 : sent_channel_count;
    drop1  = (!first_of_frame && dropping_rest) || (cnt0 >= limit);
    send   = !drop1;
    cnt1   = cnt0 + dmxfws_pkg::CNT_W'(1);
    closes = last_of_frame || (cnt1 >= limit);
  end

  assign item_ready = !qstat.full;
  assign take       = item_valid && item_ready;
  assign push       = take && (first_of_frame || send);

  always_comb begin
    entry.pre    = first_of_frame;
    entry.mbb_m1 = mbb_m1;
    entry.brk_m1 = brk_m1;
    entry.send   = send;
    entry.data   = rev;
    entry.closes = closes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_channel_count <= '0;
      dropping_rest      <= 1'b0;
    end else if (take) begin
      sent_channel_count <= send ? cnt1 : cnt0;
      dropping_rest      <= drop1 || (send && closes);
    end
  end

endmodule

`default_nettype wire

// File: design/dmxfws_queue.sv
// Short job queue between the front end and the word sequencer.
`default_nettype none

module dmxfws_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire dmxfws_pkg::entry_t push_entry,
  input  wire logic               pop,
  output dmxfws_pkg::entry_t      head,
  output dmxfws_pkg::qstat_t      qstat
);

  dmxfws_pkg::entry_t               slots [dmxfws_pkg::QDEPTH];
  logic [dmxfws_pkg::QPTR_W-1:0]    wr_ptr;
  logic [dmxfws_pkg::QPTR_W-1:0]    rd_ptr;
  logic [dmxfws_pkg::QCNT_W-1:0]    count;

  assign qstat.full  = (count == dmxfws_pkg::QCNT_W'(dmxfws_pkg::QDEPTH));
  assign qstat.empty = (count == '0);
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + dmxfws_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + dmxfws_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + dmxfws_pkg::QCNT_W'(1);
        2'b01:   count <= count - dmxfws_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/dmxfws_back.sv
// Back end: expands queued jobs into line words through a registered output stage.
`default_nettype none

module dmxfws_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire dmxfws_pkg::entry_t               head,
  input  wire dmxfws_pkg::qstat_t               qstat,
  output logic                                  pop,
  output logic                                  word_valid,
  input  wire logic                             word_ready,
  output logic [dmxfws_pkg::WORD_W-1:0]         line_word,
  output logic                                  run_last,
  output logic                                  frame_end
);

  dmxfws_pkg::phase_t            state, state_next, eff;
  logic [dmxfws_pkg::RUN_W-1:0]  cnt, cnt_next, eff_cnt;
  logic                          emit;
  logic                          done;
  logic [dmxfws_pkg::WORD_W-1:0] word;
  logic                          fend;

  assign emit = !qstat.empty && (!word_valid || word_ready);
  assign pop  = emit && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmxfws_pkg::PH_ENTRY;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    if (state == dmxfws_pkg::PH_ENTRY) begin
      eff     = head.pre ? dmxfws_pkg::PH_MARK : dmxfws_pkg::PH_CHAN;
      eff_cnt = '0;
    end else begin
      eff     = state;
      eff_cnt = cnt;
    end
    word       = dmxfws_pkg::WORD_MARK;
    fend       = 1'b0;
    done       = 1'b0;
    state_next = state;
    cnt_next   = cnt;
    case (eff)
      dmxfws_pkg::PH_MARK: begin
        word = dmxfws_pkg::WORD_MARK;
        if (emit) begin
          state_next = (eff_cnt == head.mbb_m1) ? dmxfws_pkg::PH_BREAK : dmxfws_pkg::PH_MARK;
          cnt_next   = (eff_cnt == head.mbb_m1) ? '0 : eff_cnt + dmxfws_pkg::RUN_W'(1);
        end
      end
      dmxfws_pkg::PH_BREAK: begin
        word = dmxfws_pkg::WORD_BREAK;
        if (emit) begin
          state_next = (eff_cnt == head.brk_m1) ? dmxfws_pkg::PH_MAB : dmxfws_pkg::PH_BREAK;
          cnt_next   = (eff_cnt == head.brk_m1) ? '0 : eff_cnt + dmxfws_pkg::RUN_W'(1);
        end
      end
      dmxfws_pkg::PH_MAB: begin
        word = dmxfws_pkg::WORD_MAB;
        if (emit) begin
          state_next = dmxfws_pkg::PH_START;
        end
      end
      dmxfws_pkg::PH_START: begin
        word = dmxfws_pkg::WORD_START;
        done = !head.send;
        if (emit) begin
          state_next = head.send ? dmxfws_pkg::PH_CHAN : dmxfws_pkg::PH_ENTRY;
        end
      end
      dmxfws_pkg::PH_CHAN: begin
        word = {head.data, head.closes ? dmxfws_pkg::LOW_END : dmxfws_pkg::LOW_CONT};
        fend = head.closes;
        done = 1'b1;
        if (emit) begin
          state_next = dmxfws_pkg::PH_ENTRY;
          cnt_next   = '0;
        end
      end
      default: begin
        word = dmxfws_pkg::WORD_MARK;
        if (emit) begin
          state_next = dmxfws_pkg::PH_ENTRY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (emit) begin
      word_valid <= 1'b1;
    end else if (word_ready) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      line_word <= word;
      run_last  <= done;
      frame_end <= fend;
    end
  end

endmodule

`default_nettype wire

// File: design/dmx512_frame_word_serializer.sv
// Top level of the DMX512 frame word serializer.
//
// Channel bytes arrive as beats on the item channel (item_valid/item_ready) with
// first_of_frame and last_of_frame marks. Each accepted beat yields zero or more
// 16-bit line words on the word channel (word_valid/word_ready), MSB first on the
// line. A beat that opens a frame yields mark_before_words idle words, break_words
// break words, the mark-after-break word and the start-code word ahead of its own
// channel word. A plain channel beat yields only its channel word; bytes past the
// frame's end take no sequencer time at all. Rate is set by the sequencer, which
// emits one word a cycle while word_ready stays high, so a run of channel bytes
// streams at one beat per cycle under that condition.
// A beat's first word passes the job queue, then the output register. The
// front end classifies beats into a four-entry queue, so item_ready only drops
// when that queue is full. When the receiver stalls, the output register holds
// its word and the queue fills, after which input beats are held off.
// Configuration writes are accepted every cycle (cfg_ready is tied high) and must
// only be issued while the block is idle. Reset restores the register defaults
// (one mark word, one break word, 512 channels) and empties the queue.
`default_nettype none

module dmx512_frame_word_serializer #(
  parameter int MAX_SLOTS = dmxfws_pkg::DEF_MAX_SLOTS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [dmxfws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dmxfws_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                  item_valid,
  output logic                                       item_ready,
  input  wire logic [dmxfws_pkg::BYTE_W-1:0]         channel_value,
  input  wire logic                                  first_of_frame,
  input  wire logic                                  last_of_frame,
  output logic                                       word_valid,
  input  wire logic                                  word_ready,
  output logic [dmxfws_pkg::WORD_W-1:0]              line_word,
  output logic                                       run_last,
  output logic                                       frame_end
);

  dmxfws_pkg::entry_t push_entry;
  dmxfws_pkg::entry_t head;
  dmxfws_pkg::qstat_t qstat;
  logic               push;
  logic               pop;

  // The front end owns the registers and the per-frame channel count.
  dmxfws_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .channel_value  (channel_value),
    .first_of_frame (first_of_frame),
    .last_of_frame  (last_of_frame),
    .qstat          (qstat),
    .push           (push),
    .entry          (push_entry)
  );

  dmxfws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // The back end walks the head job word by word and pops it on its last word.
  dmxfws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .line_word  (line_word),
    .run_last   (run_last),
    .frame_end  (frame_end)
  );

  // The front end must never write into a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("job pushed into a full queue");

  // The sequencer only retires a job that is present.
  assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("job popped from an empty queue");

  // A word that closes the frame is always the final word of its beat and ends at mark.
  assert property (@(posedge clk) disable iff (rst)
    (word_valid && frame_end) |-> (run_last && line_word[7:0] == dmxfws_pkg::LOW_END))
    else $error("frame end word is malformed");

endmodule

`default_nettype wire
